// File: design/ray_box_slab_intersect_macros.svh
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_macros
// Assertion macros shared by the ray/box slab test block.
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_INTERSECT_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_MACROS_SVH

`ifndef SYNTH
`define RBSI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define RBSI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RBSI_ASSERT_IMP(lbl, ante, cons)
`define RBSI_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: design/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg
// Widths, constants and types of the ray/box slab test block.
// ----------------------------------------------------------------------------
package rbsi_pkg;

	localparam int COORD_W       = 32;
	localparam int DIFF_W        = COORD_W + 1;
	localparam int DIR_W         = 18;
	localparam int THR_W         = 16;
	localparam int DIST_W        = 31;
	localparam int FRAC_BITS_DEF = 16;
	localparam int AXES          = 3;

	localparam int DIV_STEPS = COORD_W;
	localparam int DIV_LAT   = DIV_STEPS + 3;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [0:0]       REG_THRESHOLD = 1'b0;
	localparam logic [THR_W-1:0] THR_RESET     = 16'd1;

	localparam logic signed [COORD_W-1:0] T_POS_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] T_NEG_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [AXES-1:0] par;
		logic [AXES-1:0] in_slab;
	} side_t;

endpackage

// File: design/rbsi_ray_if.sv
// ----------------------------------------------------------------------------
// rbsi_ray_if
// Input channel: one ray and one box per transaction.
// ----------------------------------------------------------------------------
interface rbsi_ray_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [rbsi_pkg::COORD_W-1:0] origin_x;
	logic signed [rbsi_pkg::COORD_W-1:0] origin_y;
	logic signed [rbsi_pkg::COORD_W-1:0] origin_z;
	logic signed [rbsi_pkg::DIR_W-1:0]   dir_x;
	logic signed [rbsi_pkg::DIR_W-1:0]   dir_y;
	logic signed [rbsi_pkg::DIR_W-1:0]   dir_z;
	logic signed [rbsi_pkg::COORD_W-1:0] box_min_x;
	logic signed [rbsi_pkg::COORD_W-1:0] box_min_y;
	logic signed [rbsi_pkg::COORD_W-1:0] box_min_z;
	logic signed [rbsi_pkg::COORD_W-1:0] box_max_x;
	logic signed [rbsi_pkg::COORD_W-1:0] box_max_y;
	logic signed [rbsi_pkg::COORD_W-1:0] box_max_z;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, output ready);
endinterface

// File: design/rbsi_hit_if.sv
// ----------------------------------------------------------------------------
// rbsi_hit_if
// Output channel: hit flag and entry distance per transaction.
// ----------------------------------------------------------------------------
interface rbsi_hit_if;
	logic                           valid;
	logic                           ready;
	logic                           hit;
	logic [rbsi_pkg::DIST_W-1:0]    distance;

	modport source (output valid, hit, distance, input ready);
	modport sink (input valid, hit, distance, output ready);
endinterface

// File: design/rbsi_div.sv
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined signed divider: (num * 2^FRAC_BITS) / den, truncated toward zero,
// saturated to 32 bits. One quotient bit per stage.
// ----------------------------------------------------------------------------
module rbsi_div #(
	parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [rbsi_pkg::DIFF_W-1:0]  num,
	input  logic signed [rbsi_pkg::DIR_W-1:0]   den,
	output logic signed [rbsi_pkg::COORD_W-1:0] quo
);
	localparam int CW = rbsi_pkg::COORD_W;
	localparam int DW = rbsi_pkg::DIR_W;
	localparam int NS = rbsi_pkg::DIV_STEPS;

	logic [CW-1:0]               num_abs;
	logic [DW-1:0]               den_abs;
	logic [CW-1:0]               mag_s1;
	logic [DW-1:0]               dmag_s1;
	logic                        neg_s1;
	logic [CW-1:0]               hi_part;

	logic [DW-1:0] rem_s  [NS+1];
	logic [CW-1:0] low_s  [NS+1];
	logic [CW-1:0] qb_s   [NS+1];
	logic [DW-1:0] dmag_s [NS+1];
	logic          ovf_s  [NS+1];
	logic          neg_s  [NS+1];

	assign num_abs = num[rbsi_pkg::DIFF_W-1] ? CW'(-num) : CW'(num);
	assign den_abs = den[DW-1] ? -den : den;
	assign hi_part = mag_s1 >> (CW - FRAC_BITS);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= num_abs;
			dmag_s1 <= den_abs;
			neg_s1  <= num[rbsi_pkg::DIFF_W-1] ^ den[DW-1];
			rem_s[0]  <= hi_part[DW-1:0];
			low_s[0]  <= mag_s1 << FRAC_BITS;
			qb_s[0]   <= '0;
			dmag_s[0] <= dmag_s1;
			ovf_s[0]  <= hi_part >= CW'(dmag_s1);
			neg_s[0]  <= neg_s1;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_step
		logic [DW:0]   shifted;
		logic          ge;
		logic [DW-1:0] diff;
		assign shifted = {rem_s[k], low_s[k][CW-1]};
		assign ge      = shifted >= {1'b0, dmag_s[k]};
		assign diff    = shifted[DW-1:0] - dmag_s[k];
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff : shifted[DW-1:0];
				low_s[k+1]  <= {low_s[k][CW-2:0], 1'b0};
				qb_s[k+1]   <= {qb_s[k][CW-2:0], ge};
				dmag_s[k+1] <= dmag_s[k];
				ovf_s[k+1]  <= ovf_s[k];
				neg_s[k+1]  <= neg_s[k];
			end
		end
	end

	logic [CW-1:0] qf;
	assign qf = qb_s[NS];

	always_ff @(posedge clk) begin
		if (en) begin
			if (!neg_s[NS]) begin
				quo <= (ovf_s[NS] || qf[CW-1]) ? rbsi_pkg::T_POS_MAX : $signed(qf);
			end else begin
				quo <= (ovf_s[NS] || qf > CW'(rbsi_pkg::T_NEG_MIN))
					? rbsi_pkg::T_NEG_MIN : $signed(-qf);
			end
		end
	end
endmodule

// File: design/ray_box_slab_intersect.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Ray versus axis-aligned box slab test in signed fixed point.
// ----------------------------------------------------------------------------
// A transaction passes the setup register, the divider pipelines and the fold registers to the result.
// Throughput: one transaction per cycle unless stalled; six dividers set the depth.
// The whole pipeline holds while the output register waits on ready.
// Reset clears all valid bits and sets parallel_threshold to 1.
module ray_box_slab_intersect #(
	parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	rbsi_ray_if.sink                        ray_in,
	rbsi_hit_if.source                      hit_out,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rbsi_pkg::PADDR_W-1:0]    paddr,
	input  logic [rbsi_pkg::PDATA_W-1:0]    pwdata,
	output logic [rbsi_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready
);
	localparam int CW = rbsi_pkg::COORD_W;
	localparam int DW = rbsi_pkg::DIR_W;
	localparam int NA = rbsi_pkg::AXES;
	localparam int DL = rbsi_pkg::DIV_LAT;

	logic [rbsi_pkg::THR_W-1:0] thr_q;
	logic                       wr_thr;

	assign pready = 1'b1;
	assign wr_thr = psel && penable && pwrite && paddr[2] == rbsi_pkg::REG_THRESHOLD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= rbsi_pkg::THR_RESET;
		end else if (wr_thr) begin
			thr_q <= pwdata[rbsi_pkg::THR_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == rbsi_pkg::REG_THRESHOLD) begin
			prdata = rbsi_pkg::PDATA_W'(thr_q);
		end
	end

	logic en;
	logic out_vld_q;

	assign en           = !out_vld_q || hit_out.ready;
	assign ray_in.ready = en;

	logic signed [CW-1:0] o_in  [NA];
	logic signed [DW-1:0] d_in  [NA];
	logic signed [CW-1:0] lo_in [NA];
	logic signed [CW-1:0] hi_in [NA];

	assign o_in  = '{ray_in.origin_x, ray_in.origin_y, ray_in.origin_z};
	assign d_in  = '{ray_in.dir_x, ray_in.dir_y, ray_in.dir_z};
	assign lo_in = '{ray_in.box_min_x, ray_in.box_min_y, ray_in.box_min_z};
	assign hi_in = '{ray_in.box_max_x, ray_in.box_max_y, ray_in.box_max_z};

	logic signed [rbsi_pkg::DIFF_W-1:0] dlo_s1 [NA];
	logic signed [rbsi_pkg::DIFF_W-1:0] dhi_s1 [NA];
	logic signed [DW-1:0]               dir_s1 [NA];
	rbsi_pkg::side_t                    side_s1;
	logic                               vld_s1;
	rbsi_pkg::side_t                    side_in;

	for (genvar a = 0; a < NA; a++) begin : g_axis_in
		logic [DW-1:0] dmag;
		assign dmag = d_in[a][DW-1] ? -d_in[a] : d_in[a];
		assign side_in.par[a]     = d_in[a] == '0 || dmag < DW'(thr_q);
		assign side_in.in_slab[a] = o_in[a] >= lo_in[a] && o_in[a] <= hi_in[a];
		always_ff @(posedge clk) begin
			if (en) begin
				dlo_s1[a] <= {lo_in[a][CW-1], lo_in[a]} - {o_in[a][CW-1], o_in[a]};
				dhi_s1[a] <= {hi_in[a][CW-1], hi_in[a]} - {o_in[a][CW-1], o_in[a]};
				dir_s1[a] <= d_in[a];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
		end
	end

	logic signed [CW-1:0] t1_d [NA];
	logic signed [CW-1:0] t2_d [NA];

	for (genvar a = 0; a < NA; a++) begin : g_div
		rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
			.clk (clk),
			.en  (en),
			.num (dlo_s1[a]),
			.den (dir_s1[a]),
			.quo (t1_d[a])
		);
		rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
			.clk (clk),
			.en  (en),
			.num (dhi_s1[a]),
			.den (dir_s1[a]),
			.quo (t2_d[a])
		);
	end

	rbsi_pkg::side_t side_sd [DL];
	logic            vld_sd  [DL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int i = 0; i < DL; i++) begin
				vld_sd[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s1    <= ray_in.valid;
			vld_sd[0] <= vld_s1;
			for (int i = 1; i < DL; i++) begin
				vld_sd[i] <= vld_sd[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sd[0] <= side_s1;
			for (int i = 1; i < DL; i++) begin
				side_sd[i] <= side_sd[i-1];
			end
		end
	end

	// order slab distances
	logic signed [CW-1:0] tn_f1 [NA];
	logic signed [CW-1:0] tf_f1 [NA];
	rbsi_pkg::side_t      side_f1;
	logic                 vld_f1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NA; a++) begin
				tn_f1[a] <= (t1_d[a] > t2_d[a]) ? t2_d[a] : t1_d[a];
				tf_f1[a] <= (t1_d[a] > t2_d[a]) ? t1_d[a] : t2_d[a];
			end
			side_f1 <= side_sd[DL-1];
		end
	end

	// fold into the interval
	logic signed [CW-1:0] tmin_f2;
	logic signed [CW-1:0] tmax_f2;
	logic                 pass_f2;
	logic                 vld_f2;
	logic signed [CW-1:0] tmin_c;
	logic signed [CW-1:0] tmax_c;
	logic                 pass_c;

	always_comb begin
		tmin_c = '0;
		tmax_c = rbsi_pkg::T_POS_MAX;
		pass_c = 1'b1;
		for (int a = 0; a < NA; a++) begin
			if (side_f1.par[a]) begin
				pass_c = pass_c && side_f1.in_slab[a];
			end else begin
				if (tn_f1[a] > tmin_c) begin
					tmin_c = tn_f1[a];
				end
				if (tf_f1[a] < tmax_c) begin
					tmax_c = tf_f1[a];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tmin_f2 <= tmin_c;
			tmax_f2 <= tmax_c;
			pass_f2 <= pass_c;
		end
	end

	logic                        hit_q;
	logic [rbsi_pkg::DIST_W-1:0] dist_q;
	logic                        hit_c;

	assign hit_c = pass_f2 && tmin_f2 <= tmax_f2;

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q  <= hit_c;
			dist_q <= hit_c ? tmin_f2[rbsi_pkg::DIST_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_f1    <= 1'b0;
			vld_f2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_f1    <= vld_sd[DL-1];
			vld_f2    <= vld_f1;
			out_vld_q <= vld_f2;
		end
	end

	assign hit_out.valid    = out_vld_q;
	assign hit_out.hit      = hit_q;
	assign hit_out.distance = dist_q;

`include "ray_box_slab_intersect_macros.svh"

	`RBSI_ASSERT_IMP(a_miss_zero, out_vld_q && !hit_q, dist_q == '0)
	`RBSI_ASSERT_NXT(a_hold_out, !en, $stable(vld_f2) && $stable(dist_q))
	`RBSI_ASSERT_NXT(a_thr_write, wr_thr, thr_q == $past(pwdata[rbsi_pkg::THR_W-1:0]))
	`RBSI_ASSERT_IMP(a_fold_range, vld_f2, tmin_f2 >= 0)
endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ray/box slab intersection block. Rays and boxes
// are pushed through the input channel under random idling and stalling, each
// accepted transaction is predicted in fixed point, and every hit result is
// compared in order against the predicted queue across several thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	typedef struct {
		logic signed [rbsi_pkg::COORD_W-1:0] org [3];
		logic signed [rbsi_pkg::DIR_W-1:0]   dir [3];
		logic signed [rbsi_pkg::COORD_W-1:0] bmin [3];
		logic signed [rbsi_pkg::COORD_W-1:0] bmax [3];
	} ray_box_t;

	typedef struct {
		logic                        hit;
		logic [rbsi_pkg::DIST_W-1:0] distance;
	} hit_res_t;

	localparam int LAT = 39;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [rbsi_pkg::PADDR_W-1:0] paddr = '0;
	logic [rbsi_pkg::PDATA_W-1:0] pwdata = '0;
	logic [rbsi_pkg::PDATA_W-1:0] prdata;
	logic pready;

	rbsi_ray_if ray_ch ();
	rbsi_hit_if hit_ch ();

	ray_box_slab_intersect DUT (
		.clk(clk), .arst_n(arst_n), .ray_in(ray_ch.sink), .hit_out(hit_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	ray_box_t pending_rays [$];
	hit_res_t expected_hits [$];
	logic [rbsi_pkg::THR_W-1:0] threshold = rbsi_pkg::THR_RESET;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;
	int errors = 0;
	logic have_item = 1'b0;
	ray_box_t cur_item;

	function automatic logic signed [63:0] sat_t(logic signed [63:0] v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic hit_res_t predict_hit(ray_box_t r);
		hit_res_t res;
		logic signed [63:0] tmin, tmax, t1, t2, tmp, o, d, lo, hi, mag;
		logic ok;
		tmin = 0;
		tmax = 64'sd2147483647;
		ok = 1'b1;
		for (int a = 0; a < 3; a++) begin
			if (ok) begin
				o = r.org[a];
				d = r.dir[a];
				lo = r.bmin[a];
				hi = r.bmax[a];
				mag = d < 0 ? -d : d;
				if (d == 0 || mag < $signed({48'd0, threshold})) begin
					ok = (o >= lo) && (o <= hi);
				end else begin
					t1 = sat_t(((lo - o) <<< rbsi_pkg::FRAC_BITS_DEF) / d);
					t2 = sat_t(((hi - o) <<< rbsi_pkg::FRAC_BITS_DEF) / d);
					if (t1 > t2) begin
						tmp = t1; t1 = t2; t2 = tmp;
					end
					if (t1 > tmin) tmin = t1;
					if (t2 < tmax) tmax = t2;
					ok = tmin <= tmax;
				end
			end
		end
		if (ok && tmin >= 0) begin
			res.hit = 1'b1;
			res.distance = tmin[rbsi_pkg::DIST_W-1:0];
		end else begin
			res.hit = 1'b0;
			res.distance = '0;
		end
		return res;
	endfunction

	// input acceptance
	always @(posedge clk) begin
		if (arst_n && ray_ch.valid && ray_ch.ready) begin
			have_item = 1'b0;
			expected_hits = {expected_hits, predict_hit(cur_item)};
		end
	end

	// driver
	always @(negedge clk) begin
		if (!have_item && pending_rays.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
			cur_item = pending_rays.pop_front();
			have_item = 1'b1;
		end
		ray_ch.valid <= have_item;
		if (have_item) begin
			ray_ch.origin_x <= cur_item.org[0];
			ray_ch.origin_y <= cur_item.org[1];
			ray_ch.origin_z <= cur_item.org[2];
			ray_ch.dir_x <= cur_item.dir[0];
			ray_ch.dir_y <= cur_item.dir[1];
			ray_ch.dir_z <= cur_item.dir[2];
			ray_ch.box_min_x <= cur_item.bmin[0];
			ray_ch.box_min_y <= cur_item.bmin[1];
			ray_ch.box_min_z <= cur_item.bmin[2];
			ray_ch.box_max_x <= cur_item.bmax[0];
			ray_ch.box_max_y <= cur_item.bmax[1];
			ray_ch.box_max_z <= cur_item.bmax[2];
		end
	end

	initial begin
		ray_ch.valid = 1'b0;
		ray_ch.origin_x = '0; ray_ch.origin_y = '0; ray_ch.origin_z = '0;
		ray_ch.dir_x = '0; ray_ch.dir_y = '0; ray_ch.dir_z = '0;
		ray_ch.box_min_x = '0; ray_ch.box_min_y = '0; ray_ch.box_min_z = '0;
		ray_ch.box_max_x = '0; ray_ch.box_max_y = '0; ray_ch.box_max_z = '0;
		hit_ch.ready = 1'b0;
	end

	// receiver
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			hit_ch.ready <= 1'b0;
		end else begin
			hit_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		hit_res_t exp_r;
		if (arst_n && hit_ch.valid && hit_ch.ready) begin
			if (expected_hits.size() == 0) begin
				$error("unexpected result hit=%0b distance=%0d", hit_ch.hit, hit_ch.distance);
				errors++;
			end else begin
				exp_r = expected_hits.pop_front();
				if (hit_ch.hit !== exp_r.hit) begin
					$error("hit expected %0b actual %0b", exp_r.hit, hit_ch.hit);
					errors++;
				end
				if (hit_ch.distance !== exp_r.distance) begin
					$error("distance expected %0d actual %0d", exp_r.distance, hit_ch.distance);
					errors++;
				end
			end
		end
	end

	task automatic write_threshold(logic [rbsi_pkg::THR_W-1:0] v);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= rbsi_pkg::PADDR_W'(rbsi_pkg::REG_THRESHOLD) << 2;
		pwdata <= rbsi_pkg::PDATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		threshold = v;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic drain();
		while (pending_rays.size() > 0 || have_item || expected_hits.size() > 0)
			@(posedge clk);
		repeat (LAT + 5) @(posedge clk);
	endtask

	function automatic logic signed [rbsi_pkg::DIR_W-1:0] rand_dir();
		case ($urandom_range(5))
			0: return 18'sd0;
			1: return $signed(18'($urandom_range(8)));
			2: return -$signed(18'($urandom_range(8)));
			3: return $urandom_range(1) ? 18'sd65536 : -18'sd65536;
			default: return $signed(18'($urandom_range(131072))) - 18'sd65536;
		endcase
	endfunction

	function automatic logic signed [rbsi_pkg::COORD_W-1:0] rand_coord(int narrow);
		if (narrow) return $signed($urandom_range(32'h00400000)) - 32'sh00200000;
		return $signed($urandom());
	endfunction

	task automatic push_random(int n);
		ray_box_t r;
		logic signed [rbsi_pkg::COORD_W-1:0] a, b;
		int narrow;
		for (int i = 0; i < n; i++) begin
			narrow = $urandom_range(9) < 8;
			for (int k = 0; k < 3; k++) begin
				r.org[k] = rand_coord(narrow);
				r.dir[k] = rand_dir();
				a = rand_coord(narrow);
				b = rand_coord(narrow);
				if ($urandom_range(9) != 0 && a > b) begin
					r.bmin[k] = b; r.bmax[k] = a;
				end else begin
					r.bmin[k] = a; r.bmax[k] = b;
				end
			end
			pending_rays = {pending_rays, r};
		end
	endtask

	task automatic push_ray(logic signed [rbsi_pkg::COORD_W-1:0] o,
			logic signed [rbsi_pkg::DIR_W-1:0] d,
			logic signed [rbsi_pkg::COORD_W-1:0] lo,
			logic signed [rbsi_pkg::COORD_W-1:0] hi);
		ray_box_t r;
		for (int k = 0; k < 3; k++) begin
			r.org[k] = o; r.dir[k] = d; r.bmin[k] = lo; r.bmax[k] = hi;
		end
		pending_rays = {pending_rays, r};
	endtask

	initial begin
		logic [rbsi_pkg::THR_W-1:0] thr_set [5];
		thr_set = '{16'd0, 16'd1, 16'd16, 16'd65535, 16'd300};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// directed: in the box, behind, parallel, zero dir, inverted box, extremes
		push_ray(0, 18'sd65536, -32'sd65536, 32'sd65536);
		push_ray(-32'sd655360, 18'sd65536, -32'sd65536, 32'sd65536);
		push_ray(32'sd655360, 18'sd65536, -32'sd65536, 32'sd65536);
		push_ray(32'sd655360, -18'sd65536, -32'sd65536, 32'sd65536);
		push_ray(0, 18'sd0, -32'sd65536, 32'sd65536);
		push_ray(32'sd131072, 18'sd0, -32'sd65536, 32'sd65536);
		push_ray(0, 18'sd0, 32'sd65536, -32'sd65536);
		push_ray(-32'sd655360, 18'sd65536, 32'sd65536, -32'sd65536);
		push_ray(-32'sh80000000, 18'sd1, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		push_ray(32'sh7FFFFFFF, -18'sd1, -32'sh80000000, -32'sh80000000);
		push_ray(-32'sh80000000, 18'sd65536, -32'sh80000000, 32'sh7FFFFFFF);
		push_ray(0, -18'sd65536, -32'sh80000000, 32'sh7FFFFFFF);
		push_ray(32'sh7FFFFFFF, 18'sd1, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		push_ray(-32'sd100, 18'sd3, 0, 32'sd5);
		push_ray(32'shFFFFFFFF, -18'sd65535, 32'sh0000FFFF, 32'sh7FFFFFFF);
		drain();
		for (int ph = 0; ph < 5; ph++) begin
			write_threshold(thr_set[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 56; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 56; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			push_random(380);
			if (ph == 0) hold_off = 300;
			drain();
		end
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end
endmodule
